### rtl/core/brmt_pkg.sv
// Shared types and constants for the binned running mean table.
`default_nettype none
package brmt_pkg;
  localparam int unsigned BinWidthCenti = 10;
  localparam logic [16:0] RecipTen = 17'd52429;
  localparam int unsigned RecipShift = 19;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  localparam int unsigned DivSteps = 33;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;
endpackage
`default_nettype wire

### rtl/core/binned_running_mean_table.sv
// Top level: temperature-binned running mean table with three divider lanes.
//   channel | dir | handshake             | payload
//   cfg     | in  | cfg_valid/cfg_ready   | cfg_data (table_min_temp)
//   in      | in  | in_valid/in_ready     | opcode temperature rate_x/y/z read_bin
//   out     | out | out_valid/out_ready   | bin_index in_range mean_x/y/z sample_count
// An update passes S_BIN, S_RD, S_RUN, the 33-step serial divide in each lane (S_DIV) and S_DONE.
// A read or an out-of-range update skips S_DIV and goes from S_RUN straight to S_DONE.
// After reset a clearing pass over all NUM_BINS entries zeroes the table; no item is taken.
// A result waits in the output register; the next item may be taken meanwhile,
// and its result holds in the last state until the previous beat leaves.
`default_nettype none
module binned_running_mean_table #(
  parameter int unsigned NUM_BINS = 512
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [15:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [0:0]         opcode,
  input  wire logic signed [15:0] temperature,
  input  wire logic signed [31:0] rate_x,
  input  wire logic signed [31:0] rate_y,
  input  wire logic signed [31:0] rate_z,
  input  wire logic [8:0]         read_bin,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [8:0]              bin_index,
  output logic                    in_range,
  output logic signed [31:0]      mean_x,
  output logic signed [31:0]      mean_y,
  output logic signed [31:0]      mean_z,
  output logic [31:0]             sample_count
);
  import brmt_pkg::*;

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_BIN  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_RUN  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic signed [15:0] min_temp;
  logic [AW-1:0]      clr_addr;
  logic               is_read;
  logic signed [16:0] diff;
  logic [8:0]         rb_q;
  logic signed [31:0] smp [3];
  logic [12:0]        bin;
  logic               ok;
  logic [32:0]        prod;
  logic [12:0]        quot;
  logic               ok_next;
  logic [12:0]        bin_next;
  logic [31:0]        mem_x [NUM_BINS];
  logic [31:0]        mem_y [NUM_BINS];
  logic [31:0]        mem_z [NUM_BINS];
  logic [31:0]        mem_c [NUM_BINS];
  logic [31:0]        rd_x, rd_y, rd_z, rd_c;
  logic               lane_start;
  logic signed [31:0] lane_mean [3];
  lane_stat_t         lane_stat [3];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_x, wr_y, wr_z, wr_c;
  logic [31:0]        cnt_next;
  logic [8:0]         res_bin;
  logic               res_ok;
  logic [31:0]        res_x, res_y, res_z, res_c;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) min_temp <= '0;
    else if (cfg_valid) min_temp <= cfg_data;
  end

  assign prod = 33'(diff[15:0]) * 33'(RecipTen);
  assign quot = prod[RecipShift +: 13];
  always_comb begin
    if (is_read) begin
      bin_next = 13'(rb_q);
      ok_next = 32'(rb_q) < NUM_BINS;
    end else if (diff[16]) begin
      bin_next = '0;
      ok_next = diff > -17'sd10;
    end else begin
      bin_next = quot;
      ok_next = 32'(quot) < NUM_BINS;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      is_read <= (opcode == OP_READ);
      diff <= 17'(temperature) - 17'(min_temp);
      rb_q <= read_bin;
      smp[0] <= rate_x;
      smp[1] <= rate_y;
      smp[2] <= rate_z;
    end
    if (state == S_BIN) begin
      bin <= bin_next;
      ok <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_x <= mem_x[bin[AW-1:0]];
      rd_y <= mem_y[bin[AW-1:0]];
      rd_z <= mem_z[bin[AW-1:0]];
      rd_c <= mem_c[bin[AW-1:0]];
    end
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_z[wr_addr] <= wr_z;
      mem_c[wr_addr] <= wr_c;
    end
  end

  assign cnt_next = (rd_c == CountMax) ? rd_c : rd_c + 32'd1;
  assign lane_start = (state == S_RUN) && !is_read && ok;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = bin[AW-1:0];
    wr_x = lane_mean[0];
    wr_y = lane_mean[1];
    wr_z = lane_mean[2];
    wr_c = cnt_next;
    if (state == S_CLR) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_x = '0;
      wr_y = '0;
      wr_z = '0;
      wr_c = '0;
    end else if (state == S_DIV && lane_stat[0].done) begin
      wr_en = 1'b1;
    end
  end

  brmt_div_lane u_lane_x (.clk, .rst, .start(lane_start), .old_mean(rd_x), .sample(smp[0]),
    .count(rd_c), .new_mean(lane_mean[0]), .stat(lane_stat[0]));
  brmt_div_lane u_lane_y (.clk, .rst, .start(lane_start), .old_mean(rd_y), .sample(smp[1]),
    .count(rd_c), .new_mean(lane_mean[1]), .stat(lane_stat[1]));
  brmt_div_lane u_lane_z (.clk, .rst, .start(lane_start), .old_mean(rd_z), .sample(smp[2]),
    .count(rd_c), .new_mean(lane_mean[2]), .stat(lane_stat[2]));

  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      res_ok <= ok;
      res_bin <= ok ? bin[8:0] : '0;
      res_x <= ok ? rd_x : '0;
      res_y <= ok ? rd_y : '0;
      res_z <= ok ? rd_z : '0;
      res_c <= ok ? rd_c : '0;
    end else if (wr_en && state == S_DIV) begin
      res_x <= lane_mean[0];
      res_y <= lane_mean[1];
      res_z <= lane_mean[2];
      res_c <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == NUM_BINS - 1) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) state <= S_BIN;
        S_BIN:  state <= S_RD;
        S_RD:   state <= S_RUN;
        S_RUN:  state <= lane_start ? S_DIV : S_DONE;
        S_DIV:  if (lane_stat[0].done) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            bin_index <= res_bin;
            in_range <= res_ok;
            mean_x <= res_x;
            mean_y <= res_y;
            mean_z <= res_z;
            sample_count <= res_c;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !in_ready) else $error("input taken during clearing pass");
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lane_stat[0].done == lane_stat[1].done && lane_stat[0].done == lane_stat[2].done)
    else $error("lanes finished apart");
  a_update_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en && state == S_DIV |-> ok && !is_read) else $error("write outside table");
  a_start_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    lane_start |-> !lane_stat[0].busy) else $error("lane restarted while busy");
`endif
endmodule
`default_nettype wire

### rtl/core/brmt_div_lane.sv
// One axis lane: serial running-mean fold, old + (sample - old) / (count + 1).
`default_nettype none
module brmt_div_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [31:0]  old_mean,
  input  wire logic signed [31:0]  sample,
  input  wire logic [31:0]         count,
  output logic signed [31:0]       new_mean,
  output brmt_pkg::lane_stat_t     stat
);
  import brmt_pkg::*;

  logic signed [31:0] old_q;
  logic               neg;
  logic [32:0]        den;
  logic [32:0]        rem;
  logic [32:0]        qd;
  logic [5:0]         cnt;
  logic signed [32:0] num;
  logic [32:0]        mag;
  logic [33:0]        rem_sh;
  logic               take;
  logic [32:0]        sq;
  logic [32:0]        sum;

  assign num = 33'(sample) - 33'(old_mean);
  assign mag = num[32] ? 33'(-num) : 33'(num);
  assign rem_sh = {rem, qd[32]};
  assign take = rem_sh >= {1'b0, den};
  assign sq = neg ? 33'(-qd) : qd;
  assign sum = 33'(old_q) + sq;
  assign new_mean = sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DivSteps - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      old_q <= old_mean;
      neg <= num[32];
      den <= 33'(count) + 33'd1;
      rem <= '0;
      qd <= mag;
    end else if (stat.busy) begin
      rem <= take ? 33'(rem_sh - {1'b0, den}) : rem_sh[32:0];
      qd <= {qd[31:0], take};
    end
  end
endmodule
`default_nettype wire
